/* rtl/weighted_score_card_scheduler_unit_defines.svh */
// Assertion macros shared by the scheduler's checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef WEIGHTED_SCORE_CARD_SCHEDULER_UNIT_DEFINES_SVH
`define WEIGHTED_SCORE_CARD_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define WSC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wsc_pkg.sv */
// Shared types and constants of the weighted score card scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsc_pkg;

   localparam logic [1:0] KIND_ARRIVE   = 2'd0;
   localparam logic [1:0] KIND_CARD_UPD = 2'd1;
   localparam logic [1:0] KIND_SCHEDULE = 2'd2;

   localparam logic [1:0] STATUS_ASSIGNED = 2'd0;
   localparam logic [1:0] STATUS_NONE     = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [2:0] CSR_WEIGHT_WAIT     = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_SWITCH   = 3'd1;
   localparam logic [2:0] CSR_WEIGHT_PRESSURE = 3'd2;
   localparam logic [2:0] CSR_WEIGHT_PRIORITY = 3'd3;
   localparam logic [2:0] CSR_ONE_CARD_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_TWO_CARD_LIMIT  = 3'd5;
   localparam logic [2:0] CSR_BASE_KEY_LOAD   = 3'd6;

   localparam logic [15:0] WEIGHT_RESET        = 16'd256;
   localparam logic [31:0] ONE_CARD_RESET      = 32'd4096;
   localparam logic [31:0] TWO_CARD_RESET      = 32'd8192;
   localparam logic [15:0] BASE_KEY_LOAD_RESET = 16'd500;

   // key bytes per unit of default load time (1024)
   localparam int KEY_SHIFT = 10;

   typedef struct packed {
      logic [15:0] request;
      logic [15:0] user;
      logic [31:0] arrival;
      logic [15:0] recip;      // Q0.16 reciprocal priority term
      logic [2:0]  need;
      logic [31:0] cost;
   } qentry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic       start;
      logic [7:0] prio;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] recip;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/weighted_score_card_scheduler_unit.sv */
// Weighted score card scheduler: a request queue held in a chain of cells, a card table,
// and a sequencer that scores request/card pairs with one shared 16x33 multiplier.
// One request at a time. An arrival waits for the 17-step reciprocal divider. A schedule
// attempt scores each queued request that fits the idle cards (four multiplies, then one
// compare per card), skips the others, emits the card group of the best request/card pair
// and then compacts the queue. Results leave through a registered output; a full queue
// or nothing schedulable gives one result with last set. Depends on wsc_pkg,
// wsc_queue_cell and wsc_recip_div.
`timescale 1ns / 1ps
`default_nettype none

module weighted_score_card_scheduler_unit
   import wsc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUM_CARDS   = 8,
   parameter int MAX_GROUP   = 4
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_kind,
   input  wire  [15:0] req_request_tag,
   input  wire  [15:0] req_user_id,
   input  wire  [31:0] req_time_value,
   input  wire  [7:0]  req_priority_req,
   input  wire  [31:0] req_in_size,
   input  wire  [3:0]  req_card_cap,
   input  wire  [31:0] req_key_size,
   input  wire  [31:0] req_key_load,
   input  wire  [2:0]  req_card_id,
   input  wire         req_card_busy,
   input  wire         req_resident_valid,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_plan_request,
   output logic [2:0]  rsp_assigned_card,
   output logic        rsp_last,

   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW  = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
   localparam int CCW = $clog2(NUM_CARDS + 1);
   localparam int ESW = $clog2(2 * NUM_CARDS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_REQ   = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_CARD  = 8'b0001_0000,
      S_EMIT  = 8'b0010_0000,
      S_SHIFT = 8'b0100_0000,
      S_ONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [15:0] ww_ff, ww_in, ws_ff, ws_in, wp_ff, wp_in, wr_ff, wr_in;
   logic [31:0] one_ff, one_in, two_ff, two_in;
   logic [15:0] base_ff, base_in;

   // card table
   logic        busy_ff [NUM_CARDS];
   logic        busy_in [NUM_CARDS];
   logic [31:0] free_ff [NUM_CARDS];
   logic [31:0] free_in [NUM_CARDS];
   logic        hres_ff [NUM_CARDS];
   logic        hres_in [NUM_CARDS];
   logic [15:0] ruser_ff [NUM_CARDS];
   logic [15:0] ruser_in [NUM_CARDS];

   // queue
   logic [QCW-1:0] count_ff, count_in;
   qentry_type     cells_q [QUEUE_DEPTH];
   qentry_type     new_ff, new_in, push_entry;
   logic           push;

   // scoring
   qentry_type         cur_ff, cur_in;
   logic [QCW-1:0]     qi_ff, qi_in;
   logic [31:0]        now_ff, now_in;
   logic [NUM_CARDS-1:0] idle_ff, idle_in, idle_new;
   logic [CCW-1:0]     nidle_ff, nidle_in;
   logic [2:0]         step_ff, step_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [15:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] acc_ff, acc_in, sw_ff, sw_in, accsw_ff, accsw_in, cand;
   logic [CCW-1:0]     card_ff, card_in;
   logic [CW-1:0]      cidx;
   logic               same_c;
   logic [31:0]        wait_t;
   logic [QCW-1:0]     press;

   logic               found_ff, found_in;
   logic signed [63:0] best_ff, best_in;
   logic [QCW-1:0]     bestq_ff, bestq_in;
   logic [CW-1:0]      bestc_ff, bestc_in;
   logic [15:0]        bestuser_ff, bestuser_in, bestreq_ff, bestreq_in;
   logic [2:0]         bestneed_ff, bestneed_in;

   // group emission
   logic [ESW-1:0] estep_ff, estep_in, ksel;
   logic [3:0]     ecnt_ff, ecnt_in, needg;
   logic [CW-1:0]  kidx, ecard;
   logic           ph1, same_k, ematch;

   // output register
   logic        ovalid_ff, ovalid_in;
   logic [1:0]  ostatus_ff, ostatus_in;
   logic [15:0] oreq_ff, oreq_in;
   logic [2:0]  ocard_ff, ocard_in;
   logic        olast_ff, olast_in;
   logic        out_free;
   logic [1:0]  status_ff, status_in;

   // arrival
   logic [2:0]  k_need;
   logic [3:0]  need_t;
   logic [31:0] cost_t;
   logic        req_acc;

   div_req_type div_req;
   div_rsp_type div_rsp;

   wsc_recip_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      push_entry       = new_ff;
      push_entry.recip = div_rsp.recip;
   end
   assign push = (state_ff == S_DIV) && div_rsp.done;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      qentry_type    nxt;
      // load, shift
      assign ctrl = {push && (count_ff == QCW'(i)),
                     (state_ff == S_SHIFT) && (QCW'(i) >= bestq_ff)};
      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign nxt = cells_q[i];
      end else begin : g_mid
         assign nxt = cells_q[i + 1];
      end
      wsc_queue_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_entry  (push_entry),
         .next_entry (nxt),
         .entry      (cells_q[i])
      );
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !ovalid_ff || !rsp_stall;

   always_comb begin
      for (int c = 0; c < NUM_CARDS; c++) begin
         idle_new[c] = !busy_ff[c] && (req_time_value >= free_ff[c]);
      end
   end

   // arrival: card need and switch cost
   always_comb begin
      if (req_in_size <= one_ff) begin
         k_need = 3'd1;
      end else if (req_in_size <= two_ff) begin
         k_need = 3'd2;
      end else begin
         k_need = 3'd4;
      end
      need_t = (req_card_cap == 4'd0 || req_card_cap > {1'b0, k_need})
               ? {1'b0, k_need} : req_card_cap;
      cost_t = (req_key_load != 32'd0) ? req_key_load
               : 32'(base_ff) + (req_key_size >> KEY_SHIFT);
   end

   // per-request operands
   always_comb begin
      wait_t = (now_ff >= cur_ff.arrival) ? (now_ff - cur_ff.arrival) : 32'd0;
      press  = count_ff - qi_ff;
      unique case (step_ff)
         3'd0: begin
            mul_a = ww_ff;
            mul_b = $signed({1'b0, wait_t});
         end
         3'd1: begin
            mul_a = wp_ff;
            mul_b = $signed(33'(press));
         end
         3'd2: begin
            mul_a = wr_ff;
            mul_b = $signed({17'd0, cur_ff.recip});
         end
         default: begin
            mul_a = ws_ff;
            mul_b = $signed({1'b0, cur_ff.cost});
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      cidx   = card_ff[CW-1:0];
      same_c = hres_ff[cidx] && (ruser_ff[cidx] == cur_ff.user);
      cand   = same_c ? acc_ff : accsw_ff;

      ph1    = (estep_ff <= ESW'(NUM_CARDS));
      ksel   = ph1 ? ESW'(estep_ff - ESW'(1)) : ESW'(estep_ff - ESW'(NUM_CARDS + 1));
      kidx   = ksel[CW-1:0];
      same_k = hres_ff[kidx] && (ruser_ff[kidx] == bestuser_ff);
      if (estep_ff == '0) begin
         ematch = 1'b1;
         ecard  = bestc_ff;
      end else begin
         ematch = idle_ff[kidx] && (kidx != bestc_ff) && (ph1 ? same_k : !same_k);
         ecard  = kidx;
      end
      needg = ({1'b0, bestneed_ff} > 4'(MAX_GROUP)) ? 4'(MAX_GROUP) : {1'b0, bestneed_ff};
   end

   always_comb begin
      state_in    = state_ff;
      ww_in = ww_ff; ws_in = ws_ff; wp_in = wp_ff; wr_in = wr_ff;
      one_in = one_ff; two_in = two_ff; base_in = base_ff;
      busy_in = busy_ff; free_in = free_ff; hres_in = hres_ff; ruser_in = ruser_ff;
      count_in    = count_ff;
      new_in      = new_ff;
      cur_in      = cur_ff;
      qi_in       = qi_ff;
      now_in      = now_ff;
      idle_in     = idle_ff;
      nidle_in    = nidle_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      sw_in       = sw_ff;
      accsw_in    = accsw_ff;
      card_in     = card_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      bestq_in    = bestq_ff;
      bestc_in    = bestc_ff;
      bestuser_in = bestuser_ff;
      bestreq_in  = bestreq_ff;
      bestneed_in = bestneed_ff;
      estep_in    = estep_ff;
      ecnt_in     = ecnt_ff;
      status_in   = status_ff;
      ovalid_in   = ovalid_ff && rsp_stall;
      ostatus_in  = ostatus_ff;
      oreq_in     = oreq_ff;
      ocard_in    = ocard_ff;
      olast_in    = olast_ff;
      div_req.start = 1'b0;
      div_req.prio  = req_priority_req;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHT_WAIT:     ww_in   = csr_wdata[15:0];
            CSR_WEIGHT_SWITCH:   ws_in   = csr_wdata[15:0];
            CSR_WEIGHT_PRESSURE: wp_in   = csr_wdata[15:0];
            CSR_WEIGHT_PRIORITY: wr_in   = csr_wdata[15:0];
            CSR_ONE_CARD_LIMIT:  one_in  = csr_wdata;
            CSR_TWO_CARD_LIMIT:  two_in  = csr_wdata;
            CSR_BASE_KEY_LOAD:   base_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_kind)
                  KIND_ARRIVE: begin
                     if (count_ff == QCW'(QUEUE_DEPTH)) begin
                        status_in = STATUS_FULL;
                        state_in  = S_ONE;
                     end else begin
                        new_in.request = req_request_tag;
                        new_in.user    = req_user_id;
                        new_in.arrival = req_time_value;
                        new_in.recip   = '0;
                        new_in.need    = need_t[2:0];
                        new_in.cost    = cost_t;
                        div_req.start  = 1'b1;
                        state_in       = S_DIV;
                     end
                  end
                  KIND_CARD_UPD: begin
                     if (32'(req_card_id) < NUM_CARDS) begin
                        busy_in[CW'(req_card_id)]  = req_card_busy;
                        free_in[CW'(req_card_id)]  = req_time_value;
                        hres_in[CW'(req_card_id)]  = req_resident_valid;
                        ruser_in[CW'(req_card_id)] = req_user_id;
                     end
                  end
                  KIND_SCHEDULE: begin
                     now_in   = req_time_value;
                     idle_in  = idle_new;
                     nidle_in = CCW'($countones(idle_new));
                     qi_in    = '0;
                     found_in = 1'b0;
                     state_in = S_REQ;
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               count_in = count_ff + QCW'(1);
               state_in = S_IDLE;
            end
         end
         S_REQ: begin
            if (qi_ff == count_ff) begin
               if (found_ff) begin
                  estep_in = '0;
                  ecnt_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  status_in = STATUS_NONE;
                  state_in  = S_ONE;
               end
            end else begin
               cur_in = cells_q[qi_ff[QW-1:0]];
               // skip a request that needs more cards than are idle
               if (int'(cells_q[qi_ff[QW-1:0]].need) > int'(nidle_ff)) begin
                  qi_in = qi_ff + QCW'(1);
               end else begin
                  step_in  = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // multiply issues in steps 0..3, its product is consumed one step later
            unique case (step_ff)
               3'd1: acc_in = 64'(prod_ff);
               3'd2: acc_in = acc_ff - 64'(prod_ff);
               3'd3: acc_in = acc_ff + 64'(prod_ff >>> 16);
               3'd4: sw_in  = 64'(prod_ff);
               3'd5: accsw_in = acc_ff - sw_ff;
               default: ;
            endcase
            if (step_ff == 3'd5) begin
               card_in  = '0;
               state_in = S_CARD;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_CARD: begin
            if (idle_ff[cidx] && (!found_ff || cand > best_ff)) begin
               found_in    = 1'b1;
               best_in     = cand;
               bestq_in    = qi_ff;
               bestc_in    = cidx;
               bestuser_in = cur_ff.user;
               bestreq_in  = cur_ff.request;
               bestneed_in = cur_ff.need;
            end
            if (card_ff == CCW'(NUM_CARDS - 1)) begin
               qi_in    = qi_ff + QCW'(1);
               state_in = S_REQ;
            end else begin
               card_in = card_ff + CCW'(1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               estep_in = estep_ff + ESW'(1);
               if (ematch) begin
                  ovalid_in  = 1'b1;
                  ostatus_in = STATUS_ASSIGNED;
                  oreq_in    = bestreq_ff;
                  ocard_in   = 3'(ecard);
                  olast_in   = (ecnt_ff + 4'd1 == needg);
                  ecnt_in    = ecnt_ff + 4'd1;
                  if (ecnt_ff + 4'd1 == needg) begin
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_SHIFT: begin
            count_in = count_ff - QCW'(1);
            state_in = S_IDLE;
         end
         S_ONE: begin
            if (out_free) begin
               ovalid_in  = 1'b1;
               ostatus_in = status_ff;
               oreq_in    = '0;
               ocard_in   = '0;
               olast_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ww_ff     <= WEIGHT_RESET;
         ws_ff     <= WEIGHT_RESET;
         wp_ff     <= WEIGHT_RESET;
         wr_ff     <= WEIGHT_RESET;
         one_ff    <= ONE_CARD_RESET;
         two_ff    <= TWO_CARD_RESET;
         base_ff   <= BASE_KEY_LOAD_RESET;
         count_ff  <= '0;
         found_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int c = 0; c < NUM_CARDS; c++) begin
            busy_ff[c]  <= 1'b0;
            free_ff[c]  <= '0;
            hres_ff[c]  <= 1'b0;
            ruser_ff[c] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ww_ff     <= ww_in;
         ws_ff     <= ws_in;
         wp_ff     <= wp_in;
         wr_ff     <= wr_in;
         one_ff    <= one_in;
         two_ff    <= two_in;
         base_ff   <= base_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         ovalid_ff <= ovalid_in;
         busy_ff   <= busy_in;
         free_ff   <= free_in;
         hres_ff   <= hres_in;
         ruser_ff  <= ruser_in;
      end
      new_ff      <= new_in;
      cur_ff      <= cur_in;
      qi_ff       <= qi_in;
      now_ff      <= now_in;
      idle_ff     <= idle_in;
      nidle_ff    <= nidle_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sw_ff       <= sw_in;
      accsw_ff    <= accsw_in;
      card_ff     <= card_in;
      best_ff     <= best_in;
      bestq_ff    <= bestq_in;
      bestc_ff    <= bestc_in;
      bestuser_ff <= bestuser_in;
      bestreq_ff  <= bestreq_in;
      bestneed_ff <= bestneed_in;
      estep_ff    <= estep_in;
      ecnt_ff     <= ecnt_in;
      status_ff   <= status_in;
      ostatus_ff  <= ostatus_in;
      oreq_ff     <= oreq_in;
      ocard_ff    <= ocard_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_status        = ostatus_ff;
   assign rsp_plan_request  = oreq_ff;
   assign rsp_assigned_card = ocard_ff;
   assign rsp_last          = olast_ff;

endmodule

`default_nettype wire

/* rtl/wsc_queue_cell.sv */
// One slot of the request queue chain; takes a new entry or its upper neighbor.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsc_queue_cell
   import wsc_pkg::*;
(
   input  wire           clock,
   input  cell_ctrl_type ctrl,
   input  qentry_type    new_entry,
   input  qentry_type    next_entry,
   output qentry_type    entry
);

   qentry_type entry_ff, entry_in;

   always_comb begin
      priority if (ctrl.load) begin
         entry_in = new_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* rtl/wsc_recip_div.sv */
// Bit-serial divider giving min(65535, 65536 / (1 + priority)), 17 steps.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsc_recip_div
   import wsc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  den_ff, den_in;
   logic [16:0] quo_ff, quo_in;
   logic [9:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      // dividend is 2^16: only the top bit is set
      trial   = {rem_ff, (cnt_ff == 5'd16)};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         rem_in  = '0;
         quo_in  = '0;
         den_in  = {1'b0, req.prio} + 9'd1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 9'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial[8:0];
            quo_in = {quo_ff[15:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp = {done_ff, (quo_ff[16] ? 16'hFFFF : quo_ff[15:0])};

endmodule

`default_nettype wire

/* rtl/wsc_checker.sv */
// Port-level checks on the scheduler's result channel, bound to the top level.
// Depends on wsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_score_card_scheduler_unit_defines.svh"

module wsc_checker
   import wsc_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_plan_request,
   input wire [2:0]  rsp_assigned_card,
   input wire        rsp_last
);

   `WSC_ASSERT_IMP(a_status_code, rsp_valid, rsp_status == STATUS_ASSIGNED || rsp_status == STATUS_NONE || rsp_status == STATUS_FULL, "bad status")
   `WSC_ASSERT_IMP(a_fail_last, rsp_valid && rsp_status != STATUS_ASSIGNED, rsp_last, "failure result without last")
   `WSC_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_status != STATUS_ASSIGNED, rsp_plan_request == 16'd0 && rsp_assigned_card == 3'd0, "failure result with payload")
   `WSC_ASSERT_NXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_assigned_card) && $stable(rsp_last), "stalled result changed")

endmodule

bind weighted_score_card_scheduler_unit wsc_checker u_wsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_plan_request  (rsp_plan_request),
   .rsp_assigned_card (rsp_assigned_card),
   .rsp_last          (rsp_last)
);

`default_nettype wire

/* sim/tb.sv */
// Testbench for weighted_score_card_scheduler_unit: queue-fed driver, clocked monitor,
// and an in-bench scheduler predictor checked field by field. Depends on wsc_pkg.
`timescale 1ns / 1ps

module tb;
   import wsc_pkg::*;

   localparam int QD = 16;
   localparam int NC = 8;
   localparam int MG = 4;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] request_tag;
      logic [15:0] user_id;
      logic [31:0] time_value;
      logic [7:0]  priority_req;
      logic [31:0] in_size;
      logic [3:0]  card_cap;
      logic [31:0] key_size;
      logic [31:0] key_load;
      logic [2:0]  card_id;
      logic        card_busy;
      logic        resident_valid;
   } sched_item_t;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] plan_request;
      logic [2:0]  assigned_card;
      logic        last;
   } plan_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [1:0]  req_kind = '0;
   logic [15:0] req_request_tag = '0;
   logic [15:0] req_user_id = '0;
   logic [31:0] req_time_value = '0;
   logic [7:0]  req_priority_req = '0;
   logic [31:0] req_in_size = '0;
   logic [3:0]  req_card_cap = '0;
   logic [31:0] req_key_size = '0;
   logic [31:0] req_key_load = '0;
   logic [2:0]  req_card_id = '0;
   logic        req_card_busy = 1'b0;
   logic        req_resident_valid = 1'b0;

   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire [1:0]   rsp_status;
   wire [15:0]  rsp_plan_request;
   wire [2:0]   rsp_assigned_card;
   wire         rsp_last;

   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   weighted_score_card_scheduler_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_request_tag(req_request_tag), .req_user_id(req_user_id),
      .req_time_value(req_time_value), .req_priority_req(req_priority_req),
      .req_in_size(req_in_size), .req_card_cap(req_card_cap),
      .req_key_size(req_key_size), .req_key_load(req_key_load),
      .req_card_id(req_card_id), .req_card_busy(req_card_busy),
      .req_resident_valid(req_resident_valid),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_plan_request(rsp_plan_request), .rsp_assigned_card(rsp_assigned_card),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic signed [15:0] w_wait, w_switch, w_press, w_prio;
   logic [31:0] lim_one, lim_two;
   logic [15:0] key_base;
   logic [15:0] q_req [QD];
   logic [15:0] q_user [QD];
   logic [31:0] q_arr [QD];
   logic [7:0]  q_prio [QD];
   logic [2:0]  q_need [QD];
   logic [31:0] q_cost [QD];
   int          q_len;
   logic        c_busy [NC];
   logic [31:0] c_free [NC];
   logic        c_res [NC];
   logic [15:0] c_user [NC];

   sched_item_t pending[$];
   plan_t       expected_plans[$];
   int          errors = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          queued_total = 0;
   int          sent_total = 0;

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   function automatic longint pair_score(int qi, int c, logic [31:0] now);
      longint wt, sw, pr, recip, p, pterm;
      wt = (now >= q_arr[qi]) ? longint'(now - q_arr[qi]) : 0;
      sw = (c_res[c] && c_user[c] == q_user[qi]) ? 0 : longint'(q_cost[qi]);
      pr = q_len - qi;
      recip = 65536 / (1 + longint'(q_prio[qi]));
      if (recip > 65535) recip = 65535;
      p = longint'(w_prio) * recip;
      pterm = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
      return longint'(w_wait) * wt - longint'(w_switch) * sw - longint'(w_press) * pr + pterm;
   endfunction

   task automatic add_plan(logic [1:0] st, logic [15:0] r, logic [2:0] c, logic l);
      plan_t p;
      p.status = st; p.plan_request = r; p.assigned_card = c; p.last = l;
      expected_plans.insert(expected_plans.size(), p);
   endtask

   task automatic add_item(sched_item_t it);
      pending.insert(pending.size(), it);
      queued_total++;
   endtask

   task automatic predict_plans(sched_item_t it);
      int idle[$];
      int order[$];
      int k, need, bq, bc;
      longint best, s;
      bit found;
      logic [15:0] u;
      if (it.kind == KIND_ARRIVE) begin
         if (q_len >= QD) begin
            add_plan(STATUS_FULL, '0, '0, 1'b1);
            return;
         end
         k = (it.in_size <= lim_one) ? 1 : (it.in_size <= lim_two) ? 2 : 4;
         need = (it.card_cap == 0 || it.card_cap > k) ? k : int'(it.card_cap);
         if (need < 1) need = 1;
         q_req[q_len] = it.request_tag;
         q_user[q_len] = it.user_id;
         q_arr[q_len] = it.time_value;
         q_prio[q_len] = it.priority_req;
         q_need[q_len] = 3'(need);
         q_cost[q_len] = (it.key_load != 0) ? it.key_load
                         : 32'(key_base) + (it.key_size >> 10);
         q_len++;
      end else if (it.kind == KIND_CARD_UPD) begin
         c_busy[it.card_id] = it.card_busy;
         c_free[it.card_id] = it.time_value;
         c_res[it.card_id] = it.resident_valid;
         c_user[it.card_id] = it.user_id;
      end else if (it.kind == KIND_SCHEDULE) begin
         found = 0; best = 0; bq = 0; bc = 0;
         for (int c = 0; c < NC; c++)
            if (!c_busy[c] && it.time_value >= c_free[c]) idle.insert(idle.size(), c);
         for (int qi = 0; qi < q_len; qi++) begin
            if (q_need[qi] > idle.size()) continue;
            foreach (idle[i]) begin
               s = pair_score(qi, idle[i], it.time_value);
               if (!found || s > best) begin
                  best = s; bq = qi; bc = idle[i]; found = 1;
               end
            end
         end
         if (!found) begin
            add_plan(STATUS_NONE, '0, '0, 1'b1);
            return;
         end
         u = q_user[bq];
         order.insert(order.size(), bc);
         foreach (idle[i])
            if (idle[i] != bc && c_res[idle[i]] && c_user[idle[i]] == u)
               order.insert(order.size(), idle[i]);
         foreach (idle[i])
            if (idle[i] != bc && !(c_res[idle[i]] && c_user[idle[i]] == u))
               order.insert(order.size(), idle[i]);
         need = q_need[bq];
         if (need > MG) need = MG;
         if (need > order.size()) need = order.size();
         for (int j = 0; j < need; j++)
            add_plan(STATUS_ASSIGNED, q_req[bq], 3'(order[j]), j + 1 == need);
         for (int qi = bq; qi + 1 < q_len; qi++) begin
            q_req[qi] = q_req[qi+1]; q_user[qi] = q_user[qi+1]; q_arr[qi] = q_arr[qi+1];
            q_prio[qi] = q_prio[qi+1]; q_need[qi] = q_need[qi+1]; q_cost[qi] = q_cost[qi+1];
         end
         q_len--;
      end
   endtask

   // driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_plans('{req_kind, req_request_tag, req_user_id, req_time_value,
                            req_priority_req, req_in_size, req_card_cap, req_key_size,
                            req_key_load, req_card_id, req_card_busy,
                            req_resident_valid});
            sent_total++;
            gap_left = gap_len();
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               sched_item_t it;
               it = pending.pop_front();
               req_valid <= 1'b1;
               req_kind <= it.kind; req_request_tag <= it.request_tag;
               req_user_id <= it.user_id; req_time_value <= it.time_value;
               req_priority_req <= it.priority_req; req_in_size <= it.in_size;
               req_card_cap <= it.card_cap; req_key_size <= it.key_size;
               req_key_load <= it.key_load; req_card_id <= it.card_id;
               req_card_busy <= it.card_busy; req_resident_valid <= it.resident_valid;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_plans.size() == 0) begin
               $display("%0t: unexpected result status=%0d req=%0d card=%0d last=%0d",
                        $time, rsp_status, rsp_plan_request, rsp_assigned_card, rsp_last);
               errors++;
            end else begin
               plan_t e;
               e = expected_plans.pop_front();
               if (rsp_status !== e.status || rsp_plan_request !== e.plan_request ||
                   rsp_assigned_card !== e.assigned_card || rsp_last !== e.last) begin
                  $display("%0t: mismatch expected status=%0d req=%0d card=%0d last=%0d",
                           $time, e.status, e.plan_request, e.assigned_card, e.last);
                  $display("%0t:          actual   status=%0d req=%0d card=%0d last=%0d",
                           $time, rsp_status, rsp_plan_request, rsp_assigned_card, rsp_last);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = gap_len();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic sched_item_t blank_item(logic [1:0] k);
      sched_item_t it;
      it = '{default: '0};
      it.kind = k;
      return it;
   endfunction

   function automatic sched_item_t rand_arrival(logic [31:0] t);
      sched_item_t it;
      it = blank_item(KIND_ARRIVE);
      it.request_tag = 16'($urandom); it.user_id = 16'($urandom_range(0, 3));
      it.time_value = t - $urandom_range(0, 3000);
      it.priority_req = 8'($urandom);
      case ($urandom_range(0, 3))
         0: it.in_size = $urandom_range(0, 5000);
         1: it.in_size = $urandom_range(4000, 9000);
         2: it.in_size = $urandom;
         default: it.in_size = $urandom_range(0, 20000);
      endcase
      it.card_cap = 4'($urandom_range(0, 8));
      it.key_size = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
      it.key_load = ($urandom_range(0, 1) == 0) ? 32'd0 :
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 5000);
      return it;
   endfunction

   function automatic sched_item_t rand_card(logic [31:0] t);
      sched_item_t it;
      it = blank_item(KIND_CARD_UPD);
      it.card_id = 3'($urandom); it.card_busy = ($urandom_range(0, 3) == 0);
      it.time_value = ($urandom_range(0, 4) == 0) ? $urandom : t - $urandom_range(0, 500) +
                      $urandom_range(0, 300);
      it.resident_valid = 1'($urandom); it.user_id = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) it.user_id = 16'($urandom);
      it.request_tag = 16'($urandom); it.in_size = $urandom; it.key_size = $urandom;
      return it;
   endfunction

   task automatic wait_idle();
      while (sent_total != queued_total || expected_plans.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WEIGHT_WAIT:     w_wait = val[15:0];
         CSR_WEIGHT_SWITCH:   w_switch = val[15:0];
         CSR_WEIGHT_PRESSURE: w_press = val[15:0];
         CSR_WEIGHT_PRIORITY: w_prio = val[15:0];
         CSR_ONE_CARD_LIMIT:  lim_one = val;
         CSR_TWO_CARD_LIMIT:  lim_two = val;
         CSR_BASE_KEY_LOAD:   key_base = val[15:0];
         default: ;
      endcase
   endtask

   task automatic run_random(int count, logic [31:0] t0);
      sched_item_t it;
      logic [31:0] now;
      now = t0;
      for (int n = 0; n < count; n++) begin
         now = now + $urandom_range(0, 400);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it = rand_arrival(now);
            4, 5: it = rand_card(now);
            6: begin
               it = blank_item(2'd3);
               it.request_tag = 16'($urandom); it.time_value = $urandom;
            end
            default: begin
               it = blank_item(KIND_SCHEDULE);
               it.time_value = ($urandom_range(0, 9) == 0) ? $urandom : now;
            end
         endcase
         add_item(it);
      end
   endtask

   initial begin
      sched_item_t it;
      w_wait = WEIGHT_RESET; w_switch = WEIGHT_RESET; w_press = WEIGHT_RESET;
      w_prio = WEIGHT_RESET; lim_one = ONE_CARD_RESET; lim_two = TWO_CARD_RESET;
      key_base = BASE_KEY_LOAD_RESET;
      q_len = 0;
      for (int c = 0; c < NC; c++) begin
         c_busy[c] = 1'b0; c_free[c] = '0; c_res[c] = 1'b0; c_user[c] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty schedule, extremes, full queue, busy cards
      add_item(blank_item(KIND_SCHEDULE));
      for (int j = 0; j < 17; j++) begin
         it = blank_item(KIND_ARRIVE);
         it.request_tag = (j == 0) ? 16'hFFFF : 16'(j);
         it.user_id = (j == 1) ? 16'hFFFF : 16'(j % 3);
         it.time_value = (j == 2) ? 32'hFFFF_FFFF : 32'(j * 10);
         it.priority_req = (j == 3) ? 8'hFF : 8'(j);
         it.in_size = (j == 4) ? 32'hFFFF_FFFF : (j == 5) ? 32'd4097 : 32'(j * 1000);
         it.card_cap = (j == 6) ? 4'd8 : (j == 7) ? 4'd1 : 4'd0;
         it.key_size = (j == 8) ? 32'hFFFF_FFFF : 32'(j * 4096);
         it.key_load = (j == 9) ? 32'hFFFF_FFFF : (j == 10) ? 32'd7 : 32'd0;
         add_item(it);
      end
      it = blank_item(KIND_CARD_UPD);
      it.card_id = 3'd7; it.card_busy = 1'b1; it.resident_valid = 1'b1;
      it.user_id = 16'hFFFF; it.time_value = 32'hFFFF_FFFF;
      add_item(it);
      it.card_id = 3'd2; it.card_busy = 1'b0; it.user_id = 16'd1; it.time_value = 32'd100;
      add_item(it);
      it = blank_item(KIND_SCHEDULE); it.time_value = 32'd50;
      add_item(it);
      it.time_value = 32'hFFFF_FFFF;
      add_item(it);
      add_item(it);
      it = blank_item(2'd3);
      add_item(it);
      // hold the sender until every pending result has come back
      wait_idle();

      csr_write(CSR_WEIGHT_WAIT, 32'h0000_7FFF);
      csr_write(CSR_WEIGHT_SWITCH, 32'h0000_8000);
      csr_write(CSR_WEIGHT_PRESSURE, 32'h0000_7FFF);
      csr_write(CSR_WEIGHT_PRIORITY, 32'h0000_8000);
      csr_write(CSR_ONE_CARD_LIMIT, 32'd0);
      csr_write(CSR_TWO_CARD_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_BASE_KEY_LOAD, 32'h0000_FFFF);
      run_random(70, 32'd1000);
      wait_idle();

      csr_write(CSR_WEIGHT_WAIT, 32'h0000_8000);
      csr_write(CSR_WEIGHT_SWITCH, 32'h0000_7FFF);
      csr_write(CSR_WEIGHT_PRESSURE, 32'h0000_8000);
      csr_write(CSR_WEIGHT_PRIORITY, 32'h0000_7FFF);
      csr_write(CSR_ONE_CARD_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_BASE_KEY_LOAD, 32'd0);
      run_random(70, 32'hFFFF_0000);
      wait_idle();

      csr_write(CSR_WEIGHT_WAIT, $urandom);
      csr_write(CSR_WEIGHT_SWITCH, $urandom);
      csr_write(CSR_WEIGHT_PRESSURE, $urandom);
      csr_write(CSR_WEIGHT_PRIORITY, $urandom);
      csr_write(CSR_ONE_CARD_LIMIT, $urandom_range(0, 6000));
      csr_write(CSR_TWO_CARD_LIMIT, $urandom_range(6000, 12000));
      csr_write(CSR_BASE_KEY_LOAD, $urandom);
      run_random(70, $urandom);
      wait_idle();

      csr_write(CSR_WEIGHT_WAIT, 32'(WEIGHT_RESET));
      csr_write(CSR_WEIGHT_SWITCH, 32'(WEIGHT_RESET));
      csr_write(CSR_WEIGHT_PRESSURE, 32'(WEIGHT_RESET));
      csr_write(CSR_WEIGHT_PRIORITY, 32'(WEIGHT_RESET));
      csr_write(CSR_ONE_CARD_LIMIT, ONE_CARD_RESET);
      csr_write(CSR_TWO_CARD_LIMIT, TWO_CARD_RESET);
      csr_write(CSR_BASE_KEY_LOAD, 32'(BASE_KEY_LOAD_RESET));
      run_random(70, 32'd0);
      wait_idle();

      if (expected_plans.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_plans.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[weighted_score_card_scheduler_unit] OK");
      end else begin
         $display("[weighted_score_card_scheduler_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[weighted_score_card_scheduler_unit] ERROR");
      $finish;
   end

endmodule
